// File: sv/pmrg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmrg_pkg
// shared types, constants and the arctangent table of the polar range grid
// ----------------------------------------------------------------------------
package pmrg_pkg;

	localparam int RANGE_W      = 16;
	localparam int ANGLE_W      = 16;
	localparam int CORDIC_STEPS = 24;
	localparam int Z_W          = 32;
	localparam int BPT_W        = 24;
	localparam int NBINS_W      = 11;
	localparam int IDX_W        = 20;

	localparam logic CMD_ADD  = 1'b0;
	localparam logic CMD_TEST = 1'b1;

	localparam logic [1:0] VERDICT_UNKNOWN = 2'd0;
	localparam logic [1:0] VERDICT_PASS    = 2'd1;
	localparam logic [1:0] VERDICT_FAIL    = 2'd2;

	localparam logic [1:0] REG_NUM_BINS    = 2'd0;
	localparam logic [1:0] REG_MIDDLE      = 2'd1;
	localparam logic [1:0] REG_BPT         = 2'd2;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_SQR,
		FR_RUN,
		FR_PUSH
	} fr_state_t;

	typedef enum logic [2:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_MUL,
		BK_IDX,
		BK_READ,
		BK_UPD
	} bk_state_t;

	typedef struct packed {
		logic               cmd;
		logic [ANGLE_W-1:0] bearing;
		logic [RANGE_W-1:0] range;
		logic [RANGE_W-1:0] tol;
	} pmrg_entry_t;

	typedef struct packed {
		logic [NBINS_W-1:0] num_bins;
		logic [ANGLE_W-1:0] middle;
		logic [BPT_W-1:0]   bpt;
	} pmrg_cfg_t;

	// atan(2^-i) with 2^32 per turn
	function automatic logic [Z_W-1:0] atan_turn(input logic [4:0] i);
		logic [Z_W-1:0] r;
		case (i)
			5'd0:  r = 32'd536870912;
			5'd1:  r = 32'd316933406;
			5'd2:  r = 32'd167458907;
			5'd3:  r = 32'd85004756;
			5'd4:  r = 32'd42667331;
			5'd5:  r = 32'd21354465;
			5'd6:  r = 32'd10680862;
			5'd7:  r = 32'd5340245;
			5'd8:  r = 32'd2670163;
			5'd9:  r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41722;
			5'd15: r = 32'd20861;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2608;
			5'd19: r = 32'd1304;
			5'd20: r = 32'd652;
			5'd21: r = 32'd326;
			5'd22: r = 32'd163;
			5'd23: r = 32'd81;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// File: sv/pmrg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmrg_front
// accepts items, runs cordic bearing and square root range for add items
// ----------------------------------------------------------------------------
module pmrg_front import pmrg_pkg::*; #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   take,
	input  logic                   cmd,
	input  logic [COORD_WIDTH-1:0] point_x,
	input  logic [COORD_WIDTH-1:0] point_y,
	input  logic [RANGE_W-1:0]     test_range,
	input  logic [ANGLE_W-1:0]     test_bearing,
	input  logic [RANGE_W-1:0]     range_tolerance,
	input  logic                   q_full,
	output logic                   q_push,
	output pmrg_entry_t            q_data,
	output logic                   active
);

	localparam int XW    = COORD_WIDTH + 27;
	localparam int K     = COORD_WIDTH + 1;
	localparam int SW    = 2 * K;
	localparam int STEPS = (K > CORDIC_STEPS) ? K : CORDIC_STEPS;

	fr_state_t state_q, state_d;

	logic                   cmd_q;
	logic                   zero_q;
	logic signed [XW-1:0]   x_q, y_q;
	logic [Z_W-1:0]         z_q;
	logic [COORD_WIDTH-1:0] ax_q, ay_q;
	logic [SW-1:0]          ax2_q, ay2_q;
	logic                   sum_q;
	logic [SW-1:0]          v_q, res_q, bit_q;
	logic [5:0]             cnt_q;
	logic [ANGLE_W-1:0]     tb_q;
	logic [RANGE_W-1:0]     tr_q, tol_q;

	logic signed [XW-1:0]   px_w, py_w;
	logic [Z_W-1:0]         zr_w;
	logic [SW-1:0]          trial_w;

	assign px_w    = XW'($signed(point_x)) <<< 24;
	assign py_w    = XW'($signed(point_y)) <<< 24;
	assign trial_w = res_q + bit_q;
	assign zr_w    = z_q + 32'h0000_8000;

	always_comb begin
		state_d = state_q;
		case (state_q)
			FR_IDLE: if (take) state_d = (cmd == CMD_TEST) ? FR_PUSH : FR_SQR;
			FR_SQR:  state_d = FR_RUN;
			FR_RUN:  if (!sum_q && cnt_q == 6'(STEPS - 1)) state_d = FR_PUSH;
			FR_PUSH: if (!q_full) state_d = FR_IDLE;
			default: state_d = FR_IDLE;
		endcase
	end

	always_comb begin
		active = (state_q != FR_IDLE);
		q_push = (state_q == FR_PUSH) && !q_full;
		q_data.cmd = cmd_q;
		q_data.tol = tol_q;
		if (cmd_q == CMD_TEST) begin
			q_data.bearing = tb_q;
			q_data.range   = tr_q;
		end else begin
			q_data.bearing = zero_q ? '0 : zr_w[Z_W-1 -: ANGLE_W];
			q_data.range   = (res_q > SW'(16'hFFFF)) ? 16'hFFFF : res_q[RANGE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			FR_IDLE: begin
				cmd_q  <= cmd;
				tb_q   <= test_bearing;
				tr_q   <= test_range;
				tol_q  <= range_tolerance;
				zero_q <= (point_x == '0) && (point_y == '0);
				ax_q   <= point_x[COORD_WIDTH-1] ? (~point_x + 1'b1) : point_x;
				ay_q   <= point_y[COORD_WIDTH-1] ? (~point_y + 1'b1) : point_y;
				if (point_x[COORD_WIDTH-1]) begin
					x_q <= -px_w;
					y_q <= -py_w;
					z_q <= 32'h8000_0000;
				end else begin
					x_q <= px_w;
					y_q <= py_w;
					z_q <= '0;
				end
			end
			FR_SQR: begin
				ax2_q <= SW'(ax_q) * SW'(ax_q);
				ay2_q <= SW'(ay_q) * SW'(ay_q);
				sum_q <= 1'b1;
				cnt_q <= '0;
			end
			FR_RUN: begin
				if (sum_q) begin
					// squares are registered, form the radicand
					v_q   <= ax2_q + ay2_q;
					res_q <= '0;
					bit_q <= SW'(1) << (SW - 2);
					sum_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q < 6'(CORDIC_STEPS)) begin
						if (!y_q[XW-1]) begin
							x_q <= x_q + (y_q >>> cnt_q);
							y_q <= y_q - (x_q >>> cnt_q);
							z_q <= z_q + atan_turn(cnt_q[4:0]);
						end else begin
							x_q <= x_q - (y_q >>> cnt_q);
							y_q <= y_q + (x_q >>> cnt_q);
							z_q <= z_q - atan_turn(cnt_q[4:0]);
						end
					end
					if (cnt_q < 6'(K)) begin
						if (v_q >= trial_w) begin
							v_q   <= v_q - trial_w;
							res_q <= (res_q >> 1) + bit_q;
						end else begin
							res_q <= res_q >> 1;
						end
						bit_q <= bit_q >> 2;
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// File: sv/pmrg_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmrg_fifo
// short queue of classified items between front and back
// ----------------------------------------------------------------------------
module pmrg_fifo import pmrg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  pmrg_entry_t wdata,
	input  logic        pop,
	output pmrg_entry_t rdata,
	output logic        empty,
	output logic        full
);

	pmrg_entry_t mem_q [4];
	logic [1:0]  wp_q, rp_q;
	logic [2:0]  cnt_q;

	assign empty = (cnt_q == 3'd0);
	assign full  = (cnt_q == 3'd4);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 2'd1;
			if (pop) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {2'b0, push} - {2'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

endmodule

// File: sv/pmrg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmrg_back
// maps bearings to bins, keeps the bin memory and forms test verdicts
// ----------------------------------------------------------------------------
module pmrg_back import pmrg_pkg::*; #(
	parameter int MAX_BINS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  pmrg_cfg_t   cfg,
	input  logic        q_empty,
	input  pmrg_entry_t q_data,
	output logic        q_pop,
	output logic        clearing,
	output logic        done,
	output logic [1:0]  verdict
);

	localparam int AW = (MAX_BINS > 2) ? $clog2(MAX_BINS) : 1;
	localparam int PW = ANGLE_W + BPT_W + 1;

	bk_state_t state_q, state_d;

	logic [RANGE_W:0]           mem [MAX_BINS];
	logic [AW-1:0]              clr_q;
	pmrg_entry_t                e_q;
	logic signed [PW-1:0]       prod_q;
	logic [AW-1:0]              addr_q;
	logic                       hit_q;
	logic [RANGE_W:0]           rd_q;
	logic                       done_q;
	logic [1:0]                 verdict_q;

	logic signed [ANGLE_W-1:0]  a_w;
	logic signed [IDX_W-1:0]    n_w, idx_w;
	logic signed [RANGE_W+1:0]  d_w, ad_w, tol_w;
	logic                       upd_w;

	assign a_w = $signed(e_q.bearing - cfg.middle);

	always_comb begin
		if (cfg.num_bins == '0) n_w = IDX_W'(2);
		else if (IDX_W'(cfg.num_bins) > IDX_W'(MAX_BINS)) n_w = IDX_W'(MAX_BINS);
		else n_w = IDX_W'(cfg.num_bins);
		idx_w = IDX_W'(prod_q >>> 24) + (n_w >>> 1);
	end

	assign d_w   = $signed({2'b0, rd_q[RANGE_W-1:0]}) - $signed({2'b0, e_q.range});
	assign ad_w  = d_w[RANGE_W+1] ? -d_w : d_w;
	assign tol_w = $signed({2'b0, e_q.tol});
	assign upd_w = hit_q && (e_q.cmd == CMD_ADD)
		&& (!rd_q[RANGE_W] || rd_q[RANGE_W-1:0] > e_q.range);

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_CLEAR: if (clr_q == AW'(MAX_BINS - 1)) state_d = BK_IDLE;
			BK_IDLE:  if (!q_empty) state_d = BK_MUL;
			BK_MUL:   state_d = BK_IDX;
			BK_IDX:   state_d = BK_READ;
			BK_READ:  state_d = BK_UPD;
			BK_UPD:   state_d = BK_IDLE;
			default:  state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop    = (state_q == BK_IDLE) && !q_empty;
		clearing = (state_q == BK_CLEAR);
		done     = done_q;
		verdict  = verdict_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_CLEAR) clr_q <= clr_q + 1'b1;
			done_q  <= (state_q == BK_UPD) && (e_q.cmd == CMD_TEST);
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) e_q <= q_data;
		if (state_q == BK_MUL) prod_q <= PW'(a_w) * $signed({1'b0, cfg.bpt});
		if (state_q == BK_IDX) begin
			hit_q  <= (idx_w >= 0) && (idx_w < n_w);
			addr_q <= idx_w[AW-1:0];
		end
		if (state_q == BK_READ) rd_q <= mem[addr_q];
		if (state_q == BK_CLEAR) mem[clr_q] <= '0;
		else if (state_q == BK_UPD && upd_w) mem[addr_q] <= {1'b1, e_q.range};
		if (state_q == BK_UPD) begin
			if (!hit_q || !rd_q[RANGE_W]) verdict_q <= VERDICT_UNKNOWN;
			else if (d_w > tol_w) verdict_q <= VERDICT_FAIL;
			else if (ad_w < tol_w) verdict_q <= VERDICT_PASS;
			else verdict_q <= VERDICT_UNKNOWN;
		end
	end

endmodule

// File: sv/polar_min_range_grid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polar_min_range_grid
// polar grid of bearing bins keeping the nearest range seen in each bin
// ----------------------------------------------------------------------------
// usage
//   an item is taken at a clock edge with start high and busy low. cmd add
//   carries point_x/point_y, cmd test carries test_range, test_bearing and
//   range_tolerance. add items give no result; each test item gives one
//   verdict, shown for one cycle with done high (0 unknown, 1 pass, 2 fail).
//   the receiver cannot stall, so verdicts are never held back.
//   front: an add item keeps busy high through square, sum, the shared steps
//   of cordic and bit-serial square root, and push; a test item keeps busy
//   high for 1 cycle, in push. the front takes no new item until busy falls.
//   back: each item goes through pop, bin multiply, index, memory read and
//   update, and the next item is popped only after the update;
//   the four-entry queue lets the front start the next item while the back
//   works, and a full queue holds the front in its push cycle with busy high.
//   a test item's verdict reaches the ports through the front's push, the
//   queue and the back's steps, and is registered there.
//   reset: registers take their reset values and a clearing pass writes every
//   bin empty with busy high; config writes are still taken.
//   the apb port (registers at 0x0, 0x4, 0x8) is always ready.
// ----------------------------------------------------------------------------
module polar_min_range_grid import pmrg_pkg::*; #(
	parameter int MAX_BINS    = 1024,
	parameter int COORD_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic                   cmd,
	input  logic [COORD_WIDTH-1:0] point_x,
	input  logic [COORD_WIDTH-1:0] point_y,
	input  logic [RANGE_W-1:0]     test_range,
	input  logic [ANGLE_W-1:0]     test_bearing,
	input  logic [RANGE_W-1:0]     range_tolerance,
	output logic                   done,
	output logic [1:0]             verdict,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [3:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	pmrg_cfg_t   cfg_q;
	logic        fr_active, clearing;
	logic        q_push, q_pop, q_empty, q_full;
	pmrg_entry_t q_wdata, q_rdata;
	logic        wr_en;

	// config registers, to be written only while no item is in flight
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_bins <= NBINS_W'(256);
			cfg_q.middle   <= '0;
			cfg_q.bpt      <= BPT_W'(65536);
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_NUM_BINS: cfg_q.num_bins <= pwdata[NBINS_W-1:0];
				REG_MIDDLE:   cfg_q.middle   <= pwdata[ANGLE_W-1:0];
				REG_BPT:      cfg_q.bpt      <= pwdata[BPT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_NUM_BINS: prdata = 32'(cfg_q.num_bins);
			REG_MIDDLE:   prdata = 32'(cfg_q.middle);
			REG_BPT:      prdata = 32'(cfg_q.bpt);
			default:      prdata = '0;
		endcase
	end

	// the front holds off while busy with an item or while bins are cleared
	assign busy = fr_active || clearing;

	pmrg_front #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.take           (start && !busy),
		.cmd            (cmd),
		.point_x        (point_x),
		.point_y        (point_y),
		.test_range     (test_range),
		.test_bearing   (test_bearing),
		.range_tolerance(range_tolerance),
		.q_full         (q_full),
		.q_push         (q_push),
		.q_data         (q_wdata),
		.active         (fr_active)
	);

	pmrg_fifo u_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (q_wdata),
		.pop   (q_pop),
		.rdata (q_rdata),
		.empty (q_empty),
		.full  (q_full)
	);

	pmrg_back #(
		.MAX_BINS(MAX_BINS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_empty (q_empty),
		.q_data  (q_rdata),
		.q_pop   (q_pop),
		.clearing(clearing),
		.done    (done),
		.verdict (verdict)
	);

endmodule
